FILE: hdl/lpfr_pkg.sv
// Package for the length-prefixed frame receiver: payload structs, configuration
// layout, register indexes, result codes and frame constants.
// No dependencies.
package lpfr_pkg;

    // frame layout
    localparam int unsigned MIN_FRAME_BYTES = 4;
    localparam int unsigned COUNT_W         = 9;
    localparam int unsigned ELAPSED_W       = 17;

    // configuration register indexes and reset values
    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_BYTE    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_TICKS = 8'd1;
    localparam logic [7:0]  START_BYTE_RESET    = 8'd103;
    localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd1000;

    // input action codes
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // result event codes
    localparam logic EV_COMPLETE = 1'b0;
    localparam logic EV_TIMEOUT  = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } lpfr_in_t;

    typedef struct packed {
        logic       event_res;
        logic [7:0] msg_id;
        logic [7:0] body_len;
        logic [7:0] rx_checksum;
        logic [7:0] sum_check;
        logic       checksum_ok;
    } lpfr_out_t;

    typedef struct packed {
        logic [7:0]  start_byte;
        logic [15:0] timeout_ticks;
    } lpfr_cfg_t;

endpackage

FILE: hdl/length_prefixed_frame_receiver_unit.sv
// Length-prefixed frame receiver top level: configuration registers, frame
// core and a two-entry result buffer. Depends on lpfr_pkg, lpfr_frame_core.
// A result is registered into the output register, or into the skid entry when
// the output is held. Throughput: one input transaction per cycle; input stalls
// only when both result buffer entries are full.
// Reset (aresetn low, synchronous): idle, buffer empty, registers to defaults.
module length_prefixed_frame_receiver_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  lpfr_pkg::lpfr_in_t                    s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output lpfr_pkg::lpfr_out_t                   m_data,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [lpfr_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [lpfr_pkg::CFG_DATA_W-1:0]       cfg_data
);

    lpfr_pkg::lpfr_cfg_t cfg_reg;
    logic                res_valid;
    lpfr_pkg::lpfr_out_t res_item;
    logic                out_valid_reg;
    lpfr_pkg::lpfr_out_t out_reg;
    logic                skid_valid_reg;
    lpfr_pkg::lpfr_out_t skid_reg;
    logic                out_free;

    assign cfg_ready = 1'b1;
    assign s_ready   = !skid_valid_reg;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;
    assign out_free  = !out_valid_reg || m_ready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_byte    <= lpfr_pkg::START_BYTE_RESET;
            cfg_reg.timeout_ticks <= lpfr_pkg::TIMEOUT_TICKS_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                lpfr_pkg::CFG_START_BYTE:    cfg_reg.start_byte    <= cfg_data[7:0];
                lpfr_pkg::CFG_TIMEOUT_TICKS: cfg_reg.timeout_ticks <= cfg_data;
                default: ;
            endcase
        end
    end

    lpfr_frame_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (s_valid && s_ready),
        .in_item   (s_data),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res_item  (res_item)
    );

    // result register with skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= res_valid;
            end else begin
                out_valid_reg  <= res_valid;
            end
        end else if (res_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // result payloads
    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
                if (res_valid) begin
                    skid_reg <= res_item;
                end
            end else if (res_valid) begin
                out_reg <= res_item;
            end
        end else if (res_valid) begin
            skid_reg <= res_item;
        end
    end

endmodule

FILE: hdl/lpfr_frame_core.sv
// Frame tracking core: start detection, byte counting, checksum sum and
// tick timeout. Produces at most one result per accepted transaction.
// Depends on lpfr_pkg.
module lpfr_frame_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_accept,
    input  lpfr_pkg::lpfr_in_t  in_item,
    input  lpfr_pkg::lpfr_cfg_t cfg,
    output logic                res_valid,
    output lpfr_pkg::lpfr_out_t res_item
);

    logic                                frame_open_reg, frame_open_next;
    logic [lpfr_pkg::COUNT_W-1:0]        byte_count_reg, byte_count_next;
    logic [7:0]                          frame_id_reg, frame_id_next;
    logic [7:0]                          frame_len_reg, frame_len_next;
    logic [7:0]                          running_sum_reg, running_sum_next;
    logic [lpfr_pkg::ELAPSED_W-1:0]      elapsed_reg, elapsed_next;

    logic [lpfr_pkg::COUNT_W-1:0]        count_inc;
    logic [lpfr_pkg::COUNT_W-1:0]        frame_end;
    logic [lpfr_pkg::ELAPSED_W-1:0]      elapsed_inc;
    logic [7:0]                          calc;
    logic [7:0]                          sum_base;
    logic [lpfr_pkg::COUNT_W-1:0]        count_base;

    // next state and result for one transaction
    always_comb begin
        frame_open_next  = frame_open_reg;
        byte_count_next  = byte_count_reg;
        frame_id_next    = frame_id_reg;
        frame_len_next   = frame_len_reg;
        running_sum_next = running_sum_reg;
        elapsed_next     = elapsed_reg;
        res_valid        = 1'b0;
        res_item         = '0;
        count_base       = frame_open_reg ? byte_count_reg : '0;
        sum_base         = frame_open_reg ? running_sum_reg : 8'd0;
        count_inc        = count_base + lpfr_pkg::COUNT_W'(1);
        frame_end        = lpfr_pkg::COUNT_W'(lpfr_pkg::MIN_FRAME_BYTES)
                           + {1'b0, frame_len_reg};
        calc             = 8'd0 - sum_base;
        elapsed_inc      = (&elapsed_reg) ? elapsed_reg
                           : elapsed_reg + lpfr_pkg::ELAPSED_W'(1);

        if (in_accept) begin
            if (in_item.action == lpfr_pkg::ACT_TICK) begin
                // tick: age the open frame and drop it on timeout
                if (frame_open_reg) begin
                    elapsed_next = elapsed_inc;
                    if (elapsed_inc > {1'b0, cfg.timeout_ticks}) begin
                        frame_open_next    = 1'b0;
                        byte_count_next    = '0;
                        frame_id_next      = '0;
                        frame_len_next     = '0;
                        running_sum_next   = '0;
                        elapsed_next       = '0;
                        res_valid          = 1'b1;
                        res_item.event_res = lpfr_pkg::EV_TIMEOUT;
                    end
                end
            end else if (frame_open_reg || in_item.data_byte == cfg.start_byte) begin
                // frame byte, the start byte opens a clean frame
                if (!frame_open_reg) begin
                    frame_id_next  = '0;
                    frame_len_next = '0;
                    elapsed_next   = '0;
                end
                frame_open_next = 1'b1;
                byte_count_next = count_inc;
                if (count_inc == lpfr_pkg::COUNT_W'(2)) begin
                    frame_id_next = in_item.data_byte;
                end else if (count_inc == lpfr_pkg::COUNT_W'(3)) begin
                    frame_len_next = in_item.data_byte;
                end
                if (count_inc >= lpfr_pkg::COUNT_W'(lpfr_pkg::MIN_FRAME_BYTES)
                    && count_inc == frame_end) begin
                    res_valid              = 1'b1;
                    res_item.event_res     = lpfr_pkg::EV_COMPLETE;
                    res_item.msg_id        = frame_id_reg;
                    res_item.body_len      = frame_len_reg;
                    res_item.rx_checksum   = in_item.data_byte;
                    res_item.sum_check     = calc;
                    res_item.checksum_ok   = (calc == in_item.data_byte);
                    frame_open_next        = 1'b0;
                    byte_count_next        = '0;
                    frame_id_next          = '0;
                    frame_len_next         = '0;
                    running_sum_next       = '0;
                    elapsed_next           = '0;
                end else begin
                    running_sum_next = sum_base + in_item.data_byte;
                end
            end
        end
    end

    // frame state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_open_reg  <= 1'b0;
            byte_count_reg  <= '0;
            frame_id_reg    <= '0;
            frame_len_reg   <= '0;
            running_sum_reg <= '0;
            elapsed_reg     <= '0;
        end else begin
            frame_open_reg  <= frame_open_next;
            byte_count_reg  <= byte_count_next;
            frame_id_reg    <= frame_id_next;
            frame_len_reg   <= frame_len_next;
            running_sum_reg <= running_sum_next;
            elapsed_reg     <= elapsed_next;
        end
    end

endmodule

FILE: bench/length_prefixed_frame_receiver_unit_test.sv
// Testbench for length_prefixed_frame_receiver_unit: drives frames, noise and ticks with random
// idling on the input and result channels, predicts every frame report and compares it field by field.
// Depends on lpfr_pkg and length_prefixed_frame_receiver_unit.
module length_prefixed_frame_receiver_unit_test;

    localparam int CYCLE_LIMIT = 600000;

    // tracks frame state and holds the reports the block still owes
    class frame_report_board;
        logic [7:0]                     start_byte;
        logic [15:0]                    timeout_ticks;
        logic                           frame_open;
        logic [lpfr_pkg::COUNT_W-1:0]   byte_count;
        logic [7:0]                     frame_id;
        logic [7:0]                     frame_len;
        logic [7:0]                     running_sum;
        logic [lpfr_pkg::ELAPSED_W-1:0] elapsed_ticks;
        lpfr_pkg::lpfr_out_t            due_reports[$];
        int                             mismatches;

        function new();
            start_byte    = lpfr_pkg::START_BYTE_RESET;
            timeout_ticks = lpfr_pkg::TIMEOUT_TICKS_RESET;
            mismatches    = 0;
            drop_frame();
        endfunction

        function void drop_frame();
            frame_open    = 1'b0;
            byte_count    = '0;
            frame_id      = '0;
            frame_len     = '0;
            running_sum   = '0;
            elapsed_ticks = '0;
        endfunction

        function void write_register(logic [lpfr_pkg::CFG_INDEX_W-1:0] index,
                                     logic [lpfr_pkg::CFG_DATA_W-1:0] data);
            if (index == lpfr_pkg::CFG_START_BYTE) begin
                start_byte = data[7:0];
            end else if (index == lpfr_pkg::CFG_TIMEOUT_TICKS) begin
                timeout_ticks = data[15:0];
            end
        endfunction

        // advance the frame state by one accepted input transaction
        function void note_item(lpfr_pkg::lpfr_in_t item);
            lpfr_pkg::lpfr_out_t report;
            report = '0;
            if (item.action == lpfr_pkg::ACT_TICK) begin
                if (!frame_open) begin
                    return;
                end
                if (elapsed_ticks != {lpfr_pkg::ELAPSED_W{1'b1}}) begin
                    elapsed_ticks = elapsed_ticks + 1'b1;
                end
                if (elapsed_ticks > {1'b0, timeout_ticks}) begin
                    drop_frame();
                    report.event_res = lpfr_pkg::EV_TIMEOUT;
                    due_reports.push_back(report);
                end
                return;
            end
            if (!frame_open) begin
                if (item.data_byte != start_byte) begin
                    return;
                end
                drop_frame();
                frame_open = 1'b1;
            end
            byte_count = byte_count + 1'b1;
            if (byte_count == 2) begin
                frame_id = item.data_byte;
            end else if (byte_count == 3) begin
                frame_len = item.data_byte;
            end
            if (int'(byte_count) >= lpfr_pkg::MIN_FRAME_BYTES &&
                int'(byte_count) == lpfr_pkg::MIN_FRAME_BYTES + int'(frame_len)) begin
                report.event_res   = lpfr_pkg::EV_COMPLETE;
                report.msg_id      = frame_id;
                report.body_len    = frame_len;
                report.rx_checksum = item.data_byte;
                report.sum_check   = 8'd0 - running_sum;
                report.checksum_ok = (report.sum_check == item.data_byte);
                due_reports.push_back(report);
                drop_frame();
                return;
            end
            running_sum = running_sum + item.data_byte;
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        // match an output transaction against the oldest owed report
        function void check_report(lpfr_pkg::lpfr_out_t got);
            lpfr_pkg::lpfr_out_t want;
            if (due_reports.size() == 0) begin
                $error("unexpected report: event_res %0d msg_id %0d", got.event_res, got.msg_id);
                mismatches++;
                return;
            end
            want = due_reports.pop_front();
            compare_field("event_res", want.event_res, got.event_res);
            compare_field("msg_id", want.msg_id, got.msg_id);
            compare_field("body_len", want.body_len, got.body_len);
            compare_field("rx_checksum", want.rx_checksum, got.rx_checksum);
            compare_field("sum_check", want.sum_check, got.sum_check);
            compare_field("checksum_ok", want.checksum_ok, got.checksum_ok);
        endfunction

        function int pending();
            return due_reports.size();
        endfunction

        function void close_out();
            if (due_reports.size() != 0) begin
                $error("%0d frame reports never arrived", due_reports.size());
                mismatches++;
            end
        endfunction
    endclass

    logic                             aclk = 1'b0;
    logic                             aresetn;
    logic                             s_valid;
    logic                             s_ready;
    lpfr_pkg::lpfr_in_t               s_data;
    logic                             m_valid;
    logic                             m_ready;
    lpfr_pkg::lpfr_out_t              m_data;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [lpfr_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [lpfr_pkg::CFG_DATA_W-1:0]  cfg_data;

    frame_report_board board;
    bit                calm = 1'b0;
    int                frame_item_count = 0;
    int                cycle_count = 0;

    length_prefixed_frame_receiver_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 50);
    endfunction

    // payload length: mostly short, rarely the longest
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 72) begin
            return $urandom_range(0, 6);
        end else if (r < 98) begin
            return $urandom_range(7, 24);
        end else if (r < 99) begin
            return 255;
        end
        return $urandom_range(200, 254);
    endfunction

    function automatic lpfr_pkg::lpfr_in_t byte_item(logic [7:0] b);
        lpfr_pkg::lpfr_in_t item;
        item.action    = lpfr_pkg::ACT_BYTE;
        item.data_byte = b;
        return item;
    endfunction

    function automatic lpfr_pkg::lpfr_in_t tick_item();
        lpfr_pkg::lpfr_in_t item;
        item.action    = lpfr_pkg::ACT_TICK;
        item.data_byte = 8'($urandom_range(0, 255));
        return item;
    endfunction

    // sample every handshake at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                board.check_report(m_data);
            end
            if (s_valid && s_ready) begin
                board.note_item(s_data);
            end
            if (cfg_valid && cfg_ready) begin
                board.write_register(cfg_index, cfg_data);
            end
        end
    end

    // result side back-pressure
    initial begin
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            m_ready = 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
            stall = pick_gap();
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
        end
    end

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // one input transaction, presented at the falling edge and held until taken
    task automatic send_item(input lpfr_pkg::lpfr_in_t item);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = item;
        do @(posedge aclk); while (s_ready !== 1'b1);
        @(negedge aclk);
    endtask

    task automatic send_frame_item(input lpfr_pkg::lpfr_in_t item);
        send_item(item);
        frame_item_count++;
    endtask

    // whole frame with optional ticks between bytes
    task automatic send_frame(input logic [7:0] id, input int len, input bit good,
                              input int tick_pct);
        logic [7:0] sum;
        logic [7:0] b;
        int         pos;
        sum = board.start_byte;
        send_frame_item(byte_item(board.start_byte));
        for (pos = 1; pos <= len + 3; pos++) begin
            if ($urandom_range(0, 99) < tick_pct) begin
                send_frame_item(tick_item());
            end
            if (pos == 1) begin
                b = id;
            end else if (pos == 2) begin
                b = len[7:0];
            end else if (pos == len + 3) begin
                b = good ? 8'd0 - sum : 8'($urandom_range(0, 255));
            end else begin
                b = 8'($urandom_range(0, 255));
            end
            sum = sum + b;
            send_frame_item(byte_item(b));
        end
    endtask

    // opened frame cut short, then up to six ticks when tick_pct is nonzero
    task automatic send_broken(input int tick_pct);
        int n;
        send_frame_item(byte_item(board.start_byte));
        n = $urandom_range(0, 3);
        repeat (n) send_frame_item(byte_item(8'($urandom_range(0, 255))));
        n = (tick_pct > 0) ? $urandom_range(0, 6) : 0;
        repeat (n) send_frame_item(tick_item());
    endtask

    // line noise: random bytes and ticks
    task automatic send_noise(input int n);
        repeat (n) begin
            if ($urandom_range(0, 3) == 0) begin
                send_item(tick_item());
            end else begin
                send_item(byte_item(8'($urandom_range(0, 255))));
            end
        end
    endtask

    // hold input until every owed report is out, then let the pipe settle
    task automatic drain_results();
        s_valid = 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [lpfr_pkg::CFG_INDEX_W-1:0] index,
                             input logic [lpfr_pkg::CFG_DATA_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // random traffic, mostly well-formed frames, with a full drain half way
    task automatic run_phase(input int budget, input int tick_pct);
        int  first;
        int  kind;
        bit  paused;
        first  = frame_item_count;
        paused = 1'b0;
        while (frame_item_count - first < budget) begin
            if ($urandom_range(0, 9) == 0) begin
                calm = !calm;
            end
            kind = $urandom_range(0, 99);
            if (kind < 72) begin
                send_frame(8'($urandom_range(0, 255)), pick_len(), $urandom_range(0, 9) < 7,
                           tick_pct);
            end else if (kind < 86) begin
                send_noise($urandom_range(1, 4));
            end else begin
                send_broken(tick_pct);
            end
            if (!paused && frame_item_count - first >= budget / 2) begin
                drain_results();
                paused = 1'b1;
            end
        end
        calm = 1'b0;
    endtask

    // stimulus
    initial begin
        logic [lpfr_pkg::CFG_INDEX_W-1:0] stray_index;
        board     = new();
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // reset settings: noise, idle tick, minimal frame, start byte as id
        send_item(byte_item(8'h00));
        send_item(tick_item());
        send_item(byte_item(8'hFF));
        send_frame(8'hFF, 0, 1'b1, 0);
        send_frame(lpfr_pkg::START_BYTE_RESET, 2, 1'b0, 0);
        run_phase(220, 2);

        // zero start byte, zero timeout: first tick drops the frame
        drain_results();
        write_reg(lpfr_pkg::CFG_START_BYTE, 16'h0000);
        write_reg(lpfr_pkg::CFG_TIMEOUT_TICKS, 16'h0000);
        send_item(byte_item(8'h00));
        send_item(tick_item());
        send_item(byte_item(8'h00));
        send_item(byte_item(8'h5A));
        send_item(tick_item());
        send_frame(8'h80, 0, 1'b1, 0);
        run_phase(200, 4);

        // largest settings, plus a write to an unused register
        drain_results();
        write_reg(lpfr_pkg::CFG_START_BYTE, 16'hFFFF);
        write_reg(lpfr_pkg::CFG_TIMEOUT_TICKS, 16'hFFFF);
        stray_index = 8'(lpfr_pkg::CFG_TIMEOUT_TICKS + 1 + $urandom_range(0, 253));
        write_reg(stray_index, 16'($urandom_range(0, 65535)));
        run_phase(220, 30);

        // short timeouts, tick heavy
        drain_results();
        write_reg(lpfr_pkg::CFG_START_BYTE, 16'($urandom_range(0, 65535)));
        write_reg(lpfr_pkg::CFG_TIMEOUT_TICKS, 16'($urandom_range(1, 12)));
        run_phase(260, 20);

        // moderate timeouts
        drain_results();
        write_reg(lpfr_pkg::CFG_START_BYTE, 16'($urandom_range(0, 255)));
        write_reg(lpfr_pkg::CFG_TIMEOUT_TICKS, 16'($urandom_range(0, 300)));
        run_phase(260, 10);

        drain_results();
        repeat (8) @(negedge aclk);
        board.close_out();
        if (board.mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: length_prefixed_frame_receiver_unit.f
hdl/lpfr_pkg.sv
hdl/lpfr_frame_core.sv
hdl/length_prefixed_frame_receiver_unit.sv
bench/length_prefixed_frame_receiver_unit_test.sv
